/* rtl/ols_pkg.sv */
package ols_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_FRONT = 2'd0,
        ACT_INS_BACK  = 2'd1,
        ACT_FIND      = 2'd2,
        ACT_DELETE    = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_LOAD,
        CELL_PULL
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     cmp;
    } cell_ctrl_t;

endpackage

/* rtl/ordered_list_store_core.sv */
// Ordered store of up to CAPACITY 32-bit values held in a row of cells, one
// value per cell. An accepted beat goes through capture, a compare in every
// cell and an update before its result is registered; in the update the
// cells shift (back for insert at front, forward from the first match for
// delete) or the first free cell takes the value (insert at back); the count
// updates. A new beat is taken once the last one has left the update step;
// the result waits in an output register, so the next beat may enter.
module ordered_list_store_core
    import ols_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [ACTION_W-1:0]        s_action,
    input  logic signed [DATA_W-1:0]   s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic [COUNT_W-1:0]         m_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    state_t               state_reg, state_next;
    action_t              action_reg, action_next;
    logic [DATA_W-1:0]    value_reg, value_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic [COUNT_W-1:0]   m_count_reg, m_count_next;

    cell_ctrl_t           ctrl;
    logic                 full;
    logic                 found;
    logic                 commit;
    status_t              status_new;

    logic [DATA_W-1:0]    entry [CAPACITY];
    logic [CAPACITY:0]    hit;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_count  = m_count_reg;

    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign found  = hit[CAPACITY];
    assign commit = (state_reg == ST_UPD) && (!m_valid_reg || m_ready);

    assign hit[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_e, right_e;
        if (i == 0) begin : g_first
            assign left_e = value_reg;
        end else begin : g_mid
            assign left_e = entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_e = entry[i];
        end else begin : g_inner
            assign right_e = entry[i+1];
        end
        ols_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .idx         (CNT_W'(i)),
            .count       (count_reg),
            .value       (value_reg),
            .left_entry  (left_e),
            .right_entry (right_e),
            .hit_in      (hit[i]),
            .entry       (entry[i]),
            .hit_out     (hit[i+1])
        );
    end

    always_comb begin
        ctrl.cmp = (state_reg == ST_CMP);
        ctrl.op  = CELL_HOLD;
        if (commit) begin
            case (action_reg)
                ACT_INS_FRONT: ctrl.op = full ? CELL_HOLD : CELL_PUSH;
                ACT_INS_BACK:  ctrl.op = full ? CELL_HOLD : CELL_LOAD;
                ACT_DELETE:    ctrl.op = found ? CELL_PULL : CELL_HOLD;
                ACT_FIND:      ctrl.op = CELL_HOLD;
                default:       ctrl.op = CELL_HOLD;
            endcase
        end
    end

    always_comb begin
        status_new = STAT_OK;
        count_next = count_reg;
        case (action_reg)
            ACT_INS_FRONT, ACT_INS_BACK: begin
                if (full) status_new = STAT_FULL;
                else      count_next = count_reg + CNT_W'(1);
            end
            ACT_FIND: begin
                status_new = found ? STAT_OK : STAT_MISS;
            end
            ACT_DELETE: begin
                if (found) count_next = count_reg - CNT_W'(1);
                else       status_new = STAT_MISS;
            end
            default: status_new = STAT_OK;
        endcase
        if (!commit) count_next = count_reg;
    end

    always_comb begin
        state_next    = state_reg;
        action_next   = action_reg;
        value_next    = value_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    action_next = action_t'(s_action);
                    value_next  = s_value;
                    state_next  = ST_CMP;
                end
            end
            ST_CMP: state_next = ST_UPD;
            ST_UPD: begin
                // hold until the output register is free
                if (commit) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_new;
                    m_count_next  = COUNT_W'(count_next);
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        action_reg   <= action_next;
        value_reg    <= value_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    a_accept_to_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_CMP)
        else $error("accepted beat did not enter compare");

    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !commit |=> $stable(count_reg))
        else $error("count changed outside update");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_FULL |-> m_count == COUNT_W'(CAPACITY))
        else $error("full status with count below capacity");

    a_out_hold_full: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_valid)
        else $error("update did not produce a result");
`endif

endmodule

/* rtl/ols_cell.sv */
module ols_cell
    import ols_pkg::*;
(
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [CNT_W-1:0]  idx,
    input  logic [CNT_W-1:0]  count,
    input  logic [DATA_W-1:0] value,
    input  logic [DATA_W-1:0] left_entry,
    input  logic [DATA_W-1:0] right_entry,
    input  logic              hit_in,
    output logic [DATA_W-1:0] entry,
    output logic              hit_out
);

    logic [DATA_W-1:0] entry_reg, entry_next;
    logic              match_reg, match_next;

    // first match at or before this cell
    assign hit_out = hit_in | match_reg;
    assign entry   = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        case (ctrl.op)
            CELL_PUSH: entry_next = left_entry;
            CELL_LOAD: begin
                if (idx == count) entry_next = value;
            end
            CELL_PULL: begin
                if (hit_out) entry_next = right_entry;
            end
            CELL_HOLD: entry_next = entry_reg;
            default:   entry_next = entry_reg;
        endcase
    end

    // only occupied cells may match
    assign match_next = ctrl.cmp ? ((entry_reg == value) && (idx < count)) : match_reg;

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

endmodule

/* test/tb.sv */
module tb;
    import ols_pkg::*;

    localparam int NUM_RANDOM  = 900;
    localparam int NUM_ROWS    = 26;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AT     = 250;
    localparam int DRAIN_WAIT  = 10;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] count;
    } result_t;

    typedef struct packed {
        action_t            act;
        logic [DATA_W-1:0]  val;
        logic               typed;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } row_t;

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_valid  = 1'b0;
    logic                      s_ready;
    logic [ACTION_W-1:0]       s_action = ACT_FIND;
    logic signed [DATA_W-1:0]  s_value  = '0;
    logic                      m_valid;
    logic                      m_ready  = 1'b0;
    logic [STATUS_W-1:0]       m_status;
    logic [COUNT_W-1:0]        m_count;

    // Mirror of the stored sequence, front at index 0.
    logic [DATA_W-1:0] mirror [CAPACITY];
    int                mirror_fill = 0;
    result_t           pending_results [$];
    int                err_count   = 0;
    int                idle_cycles = 0;
    bit                sender_quiet   = 1'b0;
    bit                receiver_quiet = 1'b0;

    action_t all_actions [4] = '{ACT_INS_FRONT, ACT_INS_BACK, ACT_FIND, ACT_DELETE};

    row_t directed_rows [NUM_ROWS] = '{
        '{ACT_FIND,      32'h0000_0000, 1'b1, STAT_MISS, 5'd0},
        '{ACT_DELETE,    32'h0000_0000, 1'b1, STAT_MISS, 5'd0},
        '{ACT_INS_BACK,  32'h7FFF_FFFF, 1'b1, STAT_OK,   5'd1},
        '{ACT_INS_FRONT, 32'h8000_0000, 1'b1, STAT_OK,   5'd2},
        '{ACT_FIND,      32'h8000_0000, 1'b1, STAT_OK,   5'd2},
        '{ACT_FIND,      32'h0000_0000, 1'b1, STAT_MISS, 5'd2},
        '{ACT_INS_FRONT, 32'hFFFF_FFFF, 1'b1, STAT_OK,   5'd3},
        '{ACT_INS_BACK,  32'h0000_0000, 1'b1, STAT_OK,   5'd4},
        '{ACT_DELETE,    32'h7FFF_FFFF, 1'b0, STAT_OK,   5'd0},
        '{ACT_DELETE,    32'h0001_2345, 1'b1, STAT_MISS, 5'd3},
        '{ACT_INS_FRONT, 32'h0000_0005, 1'b0, STAT_OK,   5'd0},
        '{ACT_INS_BACK,  32'h0000_0005, 1'b0, STAT_OK,   5'd0},
        '{ACT_INS_FRONT, 32'hA5A5_A5A5, 1'b0, STAT_OK,   5'd0},
        '{ACT_INS_BACK,  32'h5A5A_5A5A, 1'b0, STAT_OK,   5'd0},
        '{ACT_INS_BACK,  32'h0000_0005, 1'b0, STAT_OK,   5'd0},
        '{ACT_INS_FRONT, 32'h0000_0001, 1'b0, STAT_OK,   5'd0},
        '{ACT_INS_BACK,  32'h0000_0002, 1'b0, STAT_OK,   5'd0},
        '{ACT_INS_FRONT, 32'h0000_0003, 1'b0, STAT_OK,   5'd0},
        '{ACT_INS_BACK,  32'hFFFF_FFFF, 1'b0, STAT_OK,   5'd0},
        '{ACT_INS_FRONT, 32'h8000_0000, 1'b0, STAT_OK,   5'd0},
        '{ACT_INS_BACK,  32'h0000_0004, 1'b0, STAT_OK,   5'd0},
        '{ACT_INS_FRONT, 32'h0000_0005, 1'b0, STAT_OK,   5'd0},
        '{ACT_INS_BACK,  32'h7FFF_FFFF, 1'b0, STAT_OK,   5'd0},
        '{ACT_INS_FRONT, 32'h0000_0099, 1'b1, STAT_FULL, 5'd16},
        '{ACT_INS_BACK,  32'h0000_0099, 1'b1, STAT_FULL, 5'd16},
        '{ACT_DELETE,    32'h0000_0005, 1'b0, STAT_OK,   5'd0}
    };

    ordered_list_store_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .s_value  (s_value),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .m_count  (m_count)
    );

    always #5 aclk = ~aclk;

    // Apply one action to the mirror and return the status and count it yields.
    function automatic result_t apply_action(action_t act, logic [DATA_W-1:0] val);
        result_t r;
        int      hit;
        r.status = STAT_OK;
        hit      = -1;
        case (act)
            ACT_INS_FRONT, ACT_INS_BACK: begin
                if (mirror_fill >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else if (act == ACT_INS_FRONT) begin
                    for (int i = mirror_fill; i > 0; i--)
                        mirror[i] = mirror[i-1];
                    mirror[0] = val;
                    mirror_fill++;
                end else begin
                    mirror[mirror_fill] = val;
                    mirror_fill++;
                end
            end
            default: begin
                for (int i = 0; i < mirror_fill; i++)
                    if (hit < 0 && mirror[i] == val)
                        hit = i;
                if (hit < 0) begin
                    r.status = STAT_MISS;
                end else if (act == ACT_DELETE) begin
                    // close the gap left by the first match
                    for (int k = hit; k + 1 < mirror_fill; k++)
                        mirror[k] = mirror[k+1];
                    mirror_fill--;
                end
            end
        endcase
        r.count = mirror_fill[COUNT_W-1:0];
        return r;
    endfunction

    // Half the time pick a held value so finds and deletes hit.
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0, 1: begin
                if (mirror_fill > 0)
                    v = mirror[$urandom_range(0, mirror_fill - 1)];
            end
            2: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_0001;
                    2: v = 32'h0000_0005;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h8000_0000;
                    default: v = 32'h7FFF_FFFF;
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_beat(action_t act, logic [DATA_W-1:0] val, bit typed,
                             result_t typed_res);
        int      gap;
        result_t r;
        gap = sender_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_value  <= val;
        do @(posedge aclk); while (!s_ready);
        r = apply_action(act, val);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    initial begin
        result_t typed_res;
        action_t act;
        int      mode;
        int      pick;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            typed_res.status = directed_rows[i].status;
            typed_res.count  = directed_rows[i].count;
            send_beat(directed_rows[i].act, directed_rows[i].val,
                      directed_rows[i].typed, typed_res);
        end

        mode = 0;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 40 == 0)
                sender_quiet = ($urandom_range(0, 3) == 0);
            // sweep between filling, draining and an even mix
            if (n % 50 == 0)
                mode = $urandom_range(0, 2);
            pick = $urandom_range(0, 9);
            if (mode == 0)
                act = (pick < 7) ? ($urandom_range(0, 1) ? ACT_INS_BACK : ACT_INS_FRONT)
                                 : ((pick < 9) ? ACT_FIND : ACT_DELETE);
            else if (mode == 1)
                act = (pick < 2) ? ($urandom_range(0, 1) ? ACT_INS_BACK : ACT_INS_FRONT)
                                 : ((pick < 4) ? ACT_FIND : ACT_DELETE);
            else
                act = all_actions[$urandom_range(0, 3)];
            send_beat(act, pick_value(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        int stall;
        int taken;
        taken = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (taken % 40 == 0)
                receiver_quiet = ($urandom_range(0, 3) == 0);
            // hold off long enough for the block to back up into its input
            if (taken == HOLD_AT)
                stall = HOLD_CYCLES;
            else
                stall = receiver_quiet ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                if (err_count < 10)
                    $display("mismatch: unexpected beat status %0d count %0d",
                             m_status, m_count);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status || m_count !== want.count) begin
                    if (err_count < 10)
                        $display("mismatch: status %0d/%0d count %0d/%0d (expected/actual)",
                                 want.status, m_status, want.count, m_count);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

endmodule
